/* sv/rcs_pkg.sv */
// rcs_pkg: widths, codes and shared types of the roi contrast stretch block
// used by rcs_divider and roi_contrast_stretch; no dependencies
`default_nettype none

package rcs_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SCL_W     = 13;   // 20p, 21m, 19M and the denominator
  localparam int unsigned NUM_W     = 21;   // numerator, at most 255 * 4845
  localparam int unsigned DIFF_W    = PIX_W + 2;
  localparam int unsigned PROD_W    = SCL_W + 1 + DIFF_W;

  localparam logic [SCL_W-1:0] P_MUL  = SCL_W'(20);
  localparam logic [SCL_W-1:0] LO_MUL = SCL_W'(21);
  localparam logic [SCL_W-1:0] HI_MUL = SCL_W'(19);

  localparam logic [PIX_W-1:0] MIN_RESET  = '1;
  localparam logic [PIX_W-1:0] MAX_RESET  = '0;
  localparam logic [PIX_W-1:0] LOW_RESET  = '0;
  localparam logic [PIX_W-1:0] HIGH_RESET = '1;

  typedef enum logic {
    CMD_MEASURE = 1'b0,
    CMD_APPLY   = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_LOW  = 2'd0,
    REG_OUT_HIGH = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

/* sv/roi_contrast_stretch.sv */
// roi_contrast_stretch: min/max measure and linear contrast stretch of 8-bit pixels
// depends on rcs_pkg and rcs_divider
//
//   channel  dir  tdata            tuser                  note
//   s_axis   in   [7:0] pixel      [0] cmd [1] new_region measure or apply beat
//   m_axis   out  [7:0] pixel_out  -                      one beat per apply
//   cfg      in   [7:0] cfg_data   cfg_index [1:0]        out_low, out_high
//
// measure beat: the running min and max update and the block stays ready for the next beat
// apply beat outside the cuts or with a flat range: through S_CUT to S_OUT, no multiply or divide
// apply beat inside the cuts: through S_CUT, S_MUL1, S_MUL2, S_DSTART, the 21-step serial divider and S_OUT
// an apply result waits in the output register; a stall there holds the block
// after rst: running min 255, max 0, out_low 0, out_high 255; no clearing pass
`default_nettype none

module roi_contrast_stretch (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // pixel_value
  input  wire logic [1:0]                    s_axis_tuser,   // cmd, new_region
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [7:0]                    m_axis_tdata,   // pixel_out
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data
);

  localparam int unsigned PW = rcs_pkg::PIX_W;
  localparam int unsigned SW = rcs_pkg::SCL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUT,
    S_MUL1,
    S_MUL2,
    S_DSTART,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  logic [PW-1:0] running_min;
  logic [PW-1:0] running_max;
  logic [PW-1:0] out_low;
  logic [PW-1:0] out_high;
  logic [PW-1:0] pix;
  logic [PW-1:0] result;
  logic [SW-1:0] p_offset;
  logic [SW-1:0] den;
  logic signed [rcs_pkg::PROD_W-1:0] acc;

  logic          in_beat;
  logic [PW-1:0] meas_min;
  logic [PW-1:0] meas_max;
  logic [SW-1:0] p20;
  logic [SW-1:0] lo;
  logic [SW-1:0] hi;

  logic signed [SW:0]                  mul_x;
  logic signed [rcs_pkg::DIFF_W-1:0]   mul_y;
  logic signed [rcs_pkg::PROD_W-1:0]   prod;

  logic                           div_start;
  rcs_pkg::div_status_t           div_status;
  logic [rcs_pkg::NUM_W-1:0]      div_quo;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign div_start     = (state == S_DSTART);

  // measure fold
  always_comb begin
    meas_min = s_axis_tuser[1] ? rcs_pkg::MIN_RESET : running_min;
    meas_max = s_axis_tuser[1] ? rcs_pkg::MAX_RESET : running_max;
    if (s_axis_tdata < meas_min) meas_min = s_axis_tdata;
    if (s_axis_tdata > meas_max) meas_max = s_axis_tdata;
  end

  // scaled cuts
  assign p20 = SW'(pix) * rcs_pkg::P_MUL;
  assign lo  = SW'(running_min) * rcs_pkg::LO_MUL;
  assign hi  = SW'(running_max) * rcs_pkg::HI_MUL;

  // shared multiplier: d*(b-a), then den*a
  always_comb begin
    if (state == S_MUL1) begin
      mul_x = $signed({1'b0, p_offset});
      mul_y = $signed({2'b00, out_high}) - $signed({2'b00, out_low});
    end else begin
      mul_x = $signed({1'b0, den});
      mul_y = $signed({2'b00, out_low});
    end
  end
  assign prod = rcs_pkg::PROD_W'(mul_x) * rcs_pkg::PROD_W'(mul_y);

  rcs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc[rcs_pkg::NUM_W-1:0]),
    .divisor  (den),
    .status   (div_status),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_min   <= rcs_pkg::MIN_RESET;
      running_max   <= rcs_pkg::MAX_RESET;
      out_low       <= rcs_pkg::LOW_RESET;
      out_high      <= rcs_pkg::HIGH_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rcs_pkg::REG_OUT_LOW:  out_low  <= cfg_data;
          rcs_pkg::REG_OUT_HIGH: out_high <= cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            if (rcs_pkg::cmd_t'(s_axis_tuser[0]) == rcs_pkg::CMD_APPLY) begin
              pix   <= s_axis_tdata;
              state <= S_CUT;
            end else begin
              running_min <= meas_min;
              running_max <= meas_max;
            end
          end
        end
        S_CUT: begin
          p_offset <= p20 - lo;
          den      <= hi - lo;
          priority if (p20 < lo) begin
            result <= out_low;
            state  <= S_OUT;
          end else if (p20 > hi) begin
            result <= out_high;
            state  <= S_OUT;
          end else if (hi == lo) begin
            result <= out_low;
            state  <= S_OUT;
          end else begin
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          acc   <= prod;
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= acc + prod;
          state <= S_DSTART;
        end
        S_DSTART: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_status.done) begin
            result <= (div_quo > rcs_pkg::NUM_W'(8'hFF)) ? '1 : div_quo[PW-1:0];
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= result;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !div_status.busy)
    else $error("input ready while divider busy");

  a_minmax_order: assert property (@(posedge clk) disable iff (rst)
    (running_min <= running_max) || (running_min == rcs_pkg::MIN_RESET &&
    running_max == rcs_pkg::MAX_RESET))
    else $error("running min above running max");

  a_div_tracks: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_status.busy || div_status.done))
    else $error("waiting on divider that is not running");

  a_done_to_out: assert property (@(posedge clk) disable iff (rst)
    div_status.done |=> (state == S_OUT))
    else $error("divider result not taken");

endmodule

`default_nettype wire

/* sv/rcs_divider.sv */
// rcs_divider: restoring radix-2 divider, one quotient bit per cycle while busy
// depends on rcs_pkg for widths and the status struct
`default_nettype none

module rcs_divider (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [rcs_pkg::NUM_W-1:0] dividend,
  input  wire logic [rcs_pkg::SCL_W-1:0] divisor,
  output rcs_pkg::div_status_t           status,
  output logic      [rcs_pkg::NUM_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(rcs_pkg::NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(rcs_pkg::NUM_W - 1);

  logic [rcs_pkg::SCL_W-1:0] rem;
  logic [rcs_pkg::SCL_W-1:0] den;
  logic [CNT_W-1:0]          count;
  logic                      busy;
  logic                      done;

  logic [rcs_pkg::SCL_W:0]   shifted;
  logic                      fits;
  logic [rcs_pkg::SCL_W:0]   diff;

  assign shifted = {rem, quotient[rcs_pkg::NUM_W-1]};
  assign fits    = shifted >= {1'b0, den};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= '0;
        rem      <= '0;
        den      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? diff[rcs_pkg::SCL_W-1:0] : shifted[rcs_pkg::SCL_W-1:0];
        quotient <= {quotient[rcs_pkg::NUM_W-2:0], fits};
        count    <= count + CNT_W'(1);
        if (count == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire
